/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix stack engine package
// Shared constants, command codes, queue entry type and helper functions.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_STACKS  = 3;
  localparam int MAT_WORDS   = 16;
  localparam int DATA_W      = 32;
  localparam int LVL_W       = $clog2(STACK_DEPTH);
  localparam int NUM_SLOTS   = NUM_STACKS * STACK_DEPTH;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int RAM_DEPTH   = NUM_SLOTS * MAT_WORDS;
  localparam int ADDR_W      = $clog2(RAM_DEPTH);
  localparam int FULL_W      = 2 * DATA_W;
  localparam int PROD_W      = FULL_W - FRAC_BITS;
  localparam int ACC_W       = PROD_W + 2;

  // opcodes
  localparam logic [2:0] OP_IDENT     = 3'd0;
  localparam logic [2:0] OP_STAGE_LD  = 3'd1;
  localparam logic [2:0] OP_STAGE_MUL = 3'd2;
  localparam logic [2:0] OP_PUSH      = 3'd3;
  localparam logic [2:0] OP_POP       = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [1:0] SEL_INVALID = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // classified command kinds
  typedef enum logic [3:0] {
    K_NOP, K_INVALID, K_IDENT, K_STAGE, K_LOAD, K_MUL, K_PUSH, K_POP, K_READ
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [1:0]               sel;
    logic [3:0]               idx;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // matrix slot of a stack level
  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] sel,
                                                input logic [LVL_W-1:0] lvl);
    return SLOT_W'(int'(sel) * STACK_DEPTH + int'(lvl));
  endfunction

  // word address of one element of a slot
  function automatic logic [ADDR_W-1:0] mat_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [3:0] idx);
    return ADDR_W'(int'(slot) * MAT_WORDS + int'(idx));
  endfunction

  // identity matrix element
  function automatic logic signed [DATA_W-1:0] ident_elem(input logic [3:0] idx);
    logic signed [DATA_W-1:0] one;
    one = DATA_W'(1) << FRAC_BITS;
    return (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) ? one : '0;
  endfunction

endpackage

/* rtl/matrix_stack_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix stack engine
// Three 4x4 Q16.16 matrix stacks with load, multiply, push, pop and read.
// ----------------------------------------------------------------------------
// Channel   Handshake        Beats
// command   start / busy     opcode, stack_sel, elem_index, elem_value, last
// result    done (strobe)    status, read_value, level
//
// Staging, identity, pop and invalid beats finish in the idle state of the
// back end; a read runs through S_READ, a load through S_COPY, a copying
// push through S_PUSH and a multiply through S_MUL (after S_LOAD when the
// current matrix is not identity), on the single shared multiplier (64 MACs).
// A two-entry queue sits between front and back; busy is high while full.
// Synchronous reset: all stacks at level zero with identity on top.
// Results cannot be stalled; done is high for one cycle per beat.
// ----------------------------------------------------------------------------
module matrix_stack_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        opcode,
  input  logic [1:0]                        stack_sel,
  input  logic [3:0]                        elem_index,
  input  logic signed [mse_pkg::DATA_W-1:0] elem_value,
  input  logic                              last,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [mse_pkg::DATA_W-1:0] read_value,
  output logic [3:0]                        level
);

  logic          q_valid;
  logic          q_pop;
  mse_pkg::cmd_t q_cmd;

  // accept and classify
  mse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .stack_sel  (stack_sel),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .last       (last),
    .q_pop      (q_pop),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd)
  );

  // execute
  mse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .level      (level)
  );

endmodule

/* rtl/mse_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mse_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix stack engine front end
// Accepts beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mse_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [2:0]                   opcode,
  input  logic [1:0]                   stack_sel,
  input  logic [3:0]                   elem_index,
  input  logic signed [mse_pkg::DATA_W-1:0] elem_value,
  input  logic                         last,
  input  logic                         q_pop,
  output logic                         busy,
  output logic                         q_valid,
  output mse_pkg::cmd_t                q_cmd
);

  mse_pkg::cmd_t ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  mse_pkg::cmd_t cls;
  logic          push;

  // classify the incoming beat
  always_comb begin
    cls.sel   = stack_sel;
    cls.idx   = elem_index;
    cls.value = elem_value;
    unique case (opcode)
      mse_pkg::OP_IDENT:     cls.kind = mse_pkg::K_IDENT;
      mse_pkg::OP_STAGE_LD:  cls.kind = last ? mse_pkg::K_LOAD : mse_pkg::K_STAGE;
      mse_pkg::OP_STAGE_MUL: cls.kind = last ? mse_pkg::K_MUL : mse_pkg::K_STAGE;
      mse_pkg::OP_PUSH:      cls.kind = mse_pkg::K_PUSH;
      mse_pkg::OP_POP:       cls.kind = mse_pkg::K_POP;
      mse_pkg::OP_READ:      cls.kind = mse_pkg::K_READ;
      default:               cls.kind = mse_pkg::K_NOP;
    endcase
    if (stack_sel == mse_pkg::SEL_INVALID) begin
      cls.kind = mse_pkg::K_INVALID;
    end
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = ent[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/mse_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix stack engine back end
// Executes queued commands on the matrix store and returns one result each.
// ----------------------------------------------------------------------------
module mse_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  mse_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [mse_pkg::DATA_W-1:0] read_value,
  output logic [3:0]                        level
);

  typedef enum logic [2:0] {S_IDLE, S_COPY, S_PUSH, S_READ, S_LOAD, S_MUL} state_t;

  state_t                               state;
  mse_pkg::cmd_t                        cmd;
  logic [mse_pkg::LVL_W-1:0]            top [mse_pkg::NUM_STACKS];
  logic [mse_pkg::NUM_SLOTS-1:0]        mvalid;
  logic signed [mse_pkg::DATA_W-1:0]    stage [mse_pkg::MAT_WORDS];
  logic signed [mse_pkg::DATA_W-1:0]    cur [mse_pkg::MAT_WORDS];
  logic [4:0]                           cnt;
  logic [6:0]                           step;
  logic signed [mse_pkg::FULL_W-1:0]    prod;
  logic                                 prod_v;
  logic [3:0]                           prod_e;
  logic [1:0]                           prod_k;
  logic signed [mse_pkg::ACC_W-1:0]     acc;

  logic [1:0]                           q_sel;
  logic [mse_pkg::LVL_W-1:0]            q_lvl;
  logic [mse_pkg::SLOT_W-1:0]           q_slot;
  logic [mse_pkg::LVL_W-1:0]            c_lvl;
  logic [mse_pkg::SLOT_W-1:0]           c_slot;
  logic [mse_pkg::SLOT_W-1:0]           n_slot;
  logic signed [mse_pkg::PROD_W-1:0]    shifted;
  logic signed [mse_pkg::ACC_W-1:0]     sum;
  logic signed [mse_pkg::DATA_W-1:0]    sat;
  logic signed [mse_pkg::DATA_W-1:0]    mul_a;
  logic signed [mse_pkg::DATA_W-1:0]    mul_b;
  logic [3:0]                           cnt_m1;

  logic                                 ram_we;
  logic [mse_pkg::ADDR_W-1:0]           ram_waddr;
  logic [mse_pkg::DATA_W-1:0]           ram_wdata;
  logic [mse_pkg::ADDR_W-1:0]           ram_raddr;
  logic [mse_pkg::DATA_W-1:0]           ram_rdata;

  localparam logic signed [mse_pkg::ACC_W-1:0] SAT_MAX =
    mse_pkg::ACC_W'({1'b0, {(mse_pkg::DATA_W-1){1'b1}}});
  localparam logic signed [mse_pkg::ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;

  // slot lookups for the head of the queue and the command in flight
  assign q_sel  = (q_cmd.sel == mse_pkg::SEL_INVALID) ? 2'd0 : q_cmd.sel;
  assign q_lvl  = top[q_sel];
  assign q_slot = mse_pkg::slot_of(q_sel, q_lvl);
  assign c_lvl  = top[cmd.sel];
  assign c_slot = mse_pkg::slot_of(cmd.sel, c_lvl);
  assign n_slot = mse_pkg::SLOT_W'(c_slot + 1'b1);
  assign cnt_m1 = 4'(cnt - 5'd1);

  assign q_pop = (state == S_IDLE) && q_valid;

  // MAC operands: step = {col, row, k}
  assign mul_a = cur[{step[1:0], step[3:2]}];
  assign mul_b = stage[{step[5:4], step[1:0]}];

  // floor shift, accumulate, saturate
  always_comb begin
    shifted = mse_pkg::PROD_W'(prod >>> mse_pkg::FRAC_BITS);
    sum     = ((prod_k == 2'd0) ? '0 : acc) + mse_pkg::ACC_W'(shifted);
    if (sum > SAT_MAX) begin
      sat = mse_pkg::DATA_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      sat = mse_pkg::DATA_W'(SAT_MIN);
    end else begin
      sat = mse_pkg::DATA_W'(sum);
    end
  end

  // matrix store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        ram_raddr = mse_pkg::mat_addr(q_slot, q_cmd.idx);
      end
      S_COPY: begin
        ram_we    = 1'b1;
        ram_waddr = mse_pkg::mat_addr(c_slot, cnt[3:0]);
        ram_wdata = stage[cnt[3:0]];
      end
      S_PUSH: begin
        ram_raddr = mse_pkg::mat_addr(c_slot, cnt[3:0]);
        ram_we    = (cnt != 5'd0);
        ram_waddr = mse_pkg::mat_addr(n_slot, cnt_m1);
        ram_wdata = ram_rdata;
      end
      S_LOAD: begin
        ram_raddr = mse_pkg::mat_addr(c_slot, cnt[3:0]);
      end
      S_MUL: begin
        ram_we    = prod_v && (prod_k == 2'd3);
        ram_waddr = mse_pkg::mat_addr(c_slot, prod_e);
        ram_wdata = sat;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mse_ram #(
    .WIDTH (mse_pkg::DATA_W),
    .DEPTH (mse_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, stack levels and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      prod_v <= 1'b0;
      mvalid <= '0;
      for (int s = 0; s < mse_pkg::NUM_STACKS; s++) begin
        top[s] <= '0;
      end
    end else begin
      done   <= 1'b0;
      prod_v <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            status     <= mse_pkg::ST_OK;
            read_value <= '0;
            level      <= 4'(q_lvl);
            cnt        <= '0;
            step       <= '0;
            case (q_cmd.kind)
              mse_pkg::K_INVALID: begin
                status <= mse_pkg::ST_INVALID;
                level  <= '0;
                done   <= 1'b1;
              end
              mse_pkg::K_IDENT: begin
                mvalid[q_slot] <= 1'b0;
                done           <= 1'b1;
              end
              mse_pkg::K_STAGE: begin
                stage[q_cmd.idx] <= q_cmd.value;
                done             <= 1'b1;
              end
              mse_pkg::K_LOAD: begin
                stage[q_cmd.idx] <= q_cmd.value;
                state            <= S_COPY;
              end
              mse_pkg::K_MUL: begin
                stage[q_cmd.idx] <= q_cmd.value;
                if (mvalid[q_slot]) begin
                  state <= S_LOAD;
                end else begin
                  for (int i = 0; i < mse_pkg::MAT_WORDS; i++) begin
                    cur[i] <= mse_pkg::ident_elem(4'(i));
                  end
                  state <= S_MUL;
                end
              end
              mse_pkg::K_PUSH: begin
                if (q_lvl == mse_pkg::LVL_W'(mse_pkg::STACK_DEPTH - 1)) begin
                  status <= mse_pkg::ST_OVERFLOW;
                  done   <= 1'b1;
                end else if (mvalid[q_slot]) begin
                  state <= S_PUSH;
                end else begin
                  // source is identity: mark the copy as identity too
                  mvalid[mse_pkg::SLOT_W'(q_slot + 1'b1)] <= 1'b0;
                  top[q_sel] <= q_lvl + 1'b1;
                  level      <= 4'(q_lvl + 1'b1);
                  done       <= 1'b1;
                end
              end
              mse_pkg::K_POP: begin
                if (q_lvl == '0) begin
                  status <= mse_pkg::ST_UNDERFLOW;
                end else begin
                  top[q_sel] <= q_lvl - 1'b1;
                  level      <= 4'(q_lvl - 1'b1);
                end
                done <= 1'b1;
              end
              mse_pkg::K_READ: begin
                state <= S_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd15) begin
            mvalid[c_slot] <= 1'b1;
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_PUSH: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd16) begin
            mvalid[n_slot] <= 1'b1;
            top[cmd.sel]   <= c_lvl + 1'b1;
            level          <= 4'(c_lvl + 1'b1);
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_READ: begin
          read_value <= mvalid[c_slot] ? ram_rdata : mse_pkg::ident_elem(cmd.idx);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_LOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt != 5'd0) begin
            cur[cnt_m1] <= ram_rdata;
          end
          if (cnt == 5'd16) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // issue one product per cycle
          if (!step[6]) begin
            prod   <= mse_pkg::FULL_W'(mul_a) * mse_pkg::FULL_W'(mul_b);
            prod_v <= 1'b1;
            prod_e <= step[5:2];
            prod_k <= step[1:0];
            step   <= step + 1'b1;
          end
          if (prod_v) begin
            acc <= sum;
            if (prod_k == 2'd3 && prod_e == 4'd15) begin
              mvalid[c_slot] <= 1'b1;
              done           <= 1'b1;
              state          <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != S_IDLE)
    else $error("matrix store written while idle");

  a_ovf_level: assert property (@(posedge clk) disable iff (rst)
    (done && status == mse_pkg::ST_OVERFLOW) |-> level == 4'(mse_pkg::STACK_DEPTH - 1))
    else $error("overflow reported below the top level");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == mse_pkg::ST_INVALID) |-> (level == 4'd0 && read_value == '0))
    else $error("invalid selector result not cleared");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (done || state != S_IDLE))
    else $error("command taken without result or work");

endmodule

/* tb/sv/matrix_stack_engine_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix stack engine testbench
// Drives command beats through start/busy, predicts every result beat with
// an internal model of the three Q16.16 matrix stacks and checks them in
// order as they strobe out on done.
// ----------------------------------------------------------------------------

// expected result of one command beat
typedef struct {
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [3:0]  level;
} mse_result_t;

class stack_scoreboard;
  logic signed [31:0] store [mse_pkg::NUM_STACKS][mse_pkg::STACK_DEPTH][mse_pkg::MAT_WORDS];
  logic [3:0]         top [mse_pkg::NUM_STACKS];
  logic signed [31:0] operand [mse_pkg::MAT_WORDS];
  mse_result_t        pending [$];
  int                 mismatches;

  function new();
    for (int s = 0; s < mse_pkg::NUM_STACKS; s++) begin
      top[s] = 0;
      for (int l = 0; l < mse_pkg::STACK_DEPTH; l++)
        for (int i = 0; i < mse_pkg::MAT_WORDS; i++) store[s][l][i] = 0;
      set_ident(s);
    end
    for (int i = 0; i < mse_pkg::MAT_WORDS; i++) operand[i] = 0;
    mismatches = 0;
  endfunction

  function void set_ident(int s);
    for (int i = 0; i < mse_pkg::MAT_WORDS; i++)
      store[s][top[s]][i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
  endfunction

  // current := current * operand, products floored, sums saturated
  function void multiply(int s);
    logic signed [31:0] res [mse_pkg::MAT_WORDS];
    logic signed [63:0] prod;
    logic signed [63:0] acc;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(store[s][top[s]][k*4+r]) * 64'(operand[c*4+k]);
          acc += prod >>> mse_pkg::FRAC_BITS;
        end
        if (acc > 64'sh7FFF_FFFF) res[c*4+r] = 32'sh7FFF_FFFF;
        else if (acc < -64'sh8000_0000) res[c*4+r] = 32'sh8000_0000;
        else res[c*4+r] = acc[31:0];
      end
    for (int i = 0; i < mse_pkg::MAT_WORDS; i++) store[s][top[s]][i] = res[i];
  endfunction

  // note an accepted command beat
  function void note_command(logic [2:0] op, logic [1:0] sel, logic [3:0] idx,
                             logic [31:0] val, logic lst);
    mse_result_t e;
    e.status = mse_pkg::ST_OK;
    e.read_value = 0;
    e.level = 0;
    if (sel == mse_pkg::SEL_INVALID) begin
      e.status = mse_pkg::ST_INVALID;
    end else begin
      case (op)
        mse_pkg::OP_IDENT: set_ident(sel);
        mse_pkg::OP_STAGE_LD, mse_pkg::OP_STAGE_MUL: begin
          operand[idx] = val;
          if (lst) begin
            if (op == mse_pkg::OP_STAGE_LD)
              for (int i = 0; i < mse_pkg::MAT_WORDS; i++)
                store[sel][top[sel]][i] = operand[i];
            else
              multiply(sel);
          end
        end
        mse_pkg::OP_PUSH: begin
          if (int'(top[sel]) + 1 >= mse_pkg::STACK_DEPTH) e.status = mse_pkg::ST_OVERFLOW;
          else begin
            for (int i = 0; i < mse_pkg::MAT_WORDS; i++)
              store[sel][top[sel]+1][i] = store[sel][top[sel]][i];
            top[sel]++;
          end
        end
        mse_pkg::OP_POP: begin
          if (top[sel] == 0) e.status = mse_pkg::ST_UNDERFLOW;
          else top[sel]--;
        end
        mse_pkg::OP_READ: e.read_value = store[sel][top[sel]][idx];
        default: ;
      endcase
      e.level = top[sel];
    end
    pending.push_back(e);
  endfunction

  function void fail_note(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
  endfunction

  // check one result beat against the oldest expectation
  function void check_result(logic [1:0] st, logic [31:0] rv, logic [3:0] lv);
    mse_result_t e;
    if (pending.size() == 0) begin
      fail_note("unexpected result, status", 0, st);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) fail_note("status", e.status, st);
    if (rv !== e.read_value) fail_note("read_value", e.read_value, rv);
    if (lv !== e.level) fail_note("level", e.level, lv);
  endfunction
endclass

module matrix_stack_engine_unit_tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  opcode = 0;
  logic [1:0]  stack_sel = 0;
  logic [3:0]  elem_index = 0;
  logic signed [31:0] elem_value = 0;
  logic        last = 0;
  logic        done;
  logic [1:0]  status;
  logic signed [31:0] read_value;
  logic [3:0]  level;

  stack_scoreboard sb = new();
  int idle_pct = 0;

  matrix_stack_engine_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .stack_sel(stack_sel), .elem_index(elem_index), .elem_value(elem_value),
    .last(last), .done(done), .status(status), .read_value(read_value),
    .level(level)
  );

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, read_value, level);
  end

  // send one command beat; returns at the falling edge after it was accepted,
  // with start still high, so the caller drives start next
  task automatic send_beat(logic [2:0] op, logic [1:0] sel, logic [3:0] idx,
                           logic [31:0] val, logic lst);
    bit accepted;
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    opcode <= op;
    stack_sel <= sel;
    elem_index <= idx;
    elem_value <= val;
    last <= lst;
    accepted = 0;
    while (!accepted) begin
      @(posedge clk);
      accepted = !busy;
      if (accepted) sb.note_command(op, sel, idx, val, lst);
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(8, 0)) - 4) << mse_pkg::FRAC_BITS;
      3: return {{16{$urandom_range(1, 0) ? 1'b1 : 1'b0}}, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // stage a full 16-element operand in random order, then apply it
  task automatic send_matrix(logic [2:0] op, logic [1:0] sel, bit tame);
    int order [16];
    int j, t;
    logic [31:0] v;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 16; i++) begin
      if (tame) v = (order[i] % 5 == 0) ? 32'h0001_0000 + ($urandom() & 32'h3FFFF)
                                        : 32'($signed($urandom() & 32'h3FFFF) - 32'sh20000);
      else v = rand_value();
      send_beat(op, sel, 4'(order[i]), v, i == 15);
    end
  endtask

  task automatic wait_drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_item();
    logic [1:0] sel;
    sel = ($urandom_range(19, 0) == 0) ? mse_pkg::SEL_INVALID : 2'($urandom_range(2, 0));
    case ($urandom_range(11, 0))
      0, 1: send_matrix(mse_pkg::OP_STAGE_MUL, sel == mse_pkg::SEL_INVALID ? 2'd0 : sel,
                        1'($urandom_range(1, 0)));
      2: send_matrix(mse_pkg::OP_STAGE_LD, sel == mse_pkg::SEL_INVALID ? 2'd0 : sel, 0);
      3: send_beat(mse_pkg::OP_IDENT, sel, 0, 0, 0);
      4, 5: send_beat(mse_pkg::OP_PUSH, sel, 4'($urandom()), $urandom(),
                      1'($urandom_range(1, 0)));
      6, 7: send_beat(mse_pkg::OP_POP, sel, 4'($urandom()), $urandom(),
                      1'($urandom_range(1, 0)));
      8, 9, 10: send_beat(mse_pkg::OP_READ, sel, 4'($urandom()), $urandom(),
                          1'($urandom_range(1, 0)));
      // stray staging beat without last, or undefined opcodes
      default: send_beat(3'($urandom_range(7, 1) == 7 ? 7 : ($urandom_range(1, 0) ? 6 : 1)),
                         sel, 4'($urandom()), rand_value(), 0);
    endcase
  endtask

  initial begin
    int pct [4] = '{0, 49, 0, 17};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reads of identity, invalid selector, underflow, overflow
    for (int i = 0; i < 16; i++) send_beat(mse_pkg::OP_READ, 2'(i % 3), 4'(i), 0, 0);
    send_beat(mse_pkg::OP_READ, mse_pkg::SEL_INVALID, 4'hF, 32'hFFFF_FFFF, 1);
    send_beat(mse_pkg::OP_POP, 2'd1, 0, 0, 0);
    send_beat(3'd6, 2'd2, 0, 0, 0);
    send_beat(3'd7, 2'd0, 4'hF, 32'h8000_0000, 1);
    for (int i = 0; i < mse_pkg::STACK_DEPTH; i++) send_beat(mse_pkg::OP_PUSH, 2'd2, 0, 0, 0);
    send_matrix(mse_pkg::OP_STAGE_LD, 2'd2, 0);
    send_matrix(mse_pkg::OP_STAGE_MUL, 2'd2, 0);
    for (int i = 0; i < 16; i++) send_beat(mse_pkg::OP_READ, 2'd2, 4'(i), 0, 0);
    send_beat(mse_pkg::OP_IDENT, 2'd2, 0, 0, 0);
    for (int i = 0; i < mse_pkg::STACK_DEPTH; i++) send_beat(mse_pkg::OP_POP, 2'd2, 0, 0, 0);
    wait_drain();

    // random phases with different sender idling
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      for (int n = 0; n < 75; n++) random_item();
      wait_drain();
    end

    idle_pct = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
